// ===== rtl/core/mts_pkg.sv =====
// Shared constants, codes and types of the multi-timer deadline scheduler.
package mts_pkg;

    localparam int TIMER_SLOTS = 64;
    localparam int SLOT_W      = $clog2(TIMER_SLOTS);
    localparam int SCAN_W      = SLOT_W + 1;
    localparam int TIME_W      = 48;
    localparam int STAMP_W     = 32;
    localparam int IVAL_W      = 16;
    localparam int DELAY_W     = 17;
    localparam int OP_W        = 3;
    localparam int CFG_IDX_W   = 1;

    localparam logic [TIME_W-1:0]  TIME_MAX   = '1;
    localparam logic [IVAL_W-1:0]  IVAL_MAX   = '1;
    localparam logic [DELAY_W-1:0] DELAY_NONE = '1;

    localparam logic [IVAL_W-1:0] MIN_INTERVAL_RESET = 16'd50;
    localparam logic [IVAL_W-1:0] MAX_INTERVAL_RESET = 16'd10000;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 1'd1;

    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_RESET  = 3'd2;
    localparam logic [OP_W-1:0] OP_EXISTS = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

    localparam int ACT_W = 4;
    localparam logic [ACT_W-1:0] ACT_NONE    = 4'd0;
    localparam logic [ACT_W-1:0] ACT_CAPTURE = 4'd1;
    localparam logic [ACT_W-1:0] ACT_ADD     = 4'd2;
    localparam logic [ACT_W-1:0] ACT_REMOVE  = 4'd3;
    localparam logic [ACT_W-1:0] ACT_RESET   = 4'd4;
    localparam logic [ACT_W-1:0] ACT_EXISTS  = 4'd5;
    localparam logic [ACT_W-1:0] ACT_BAD     = 4'd6;
    localparam logic [ACT_W-1:0] ACT_ADVANCE = 4'd7;
    localparam logic [ACT_W-1:0] ACT_FIRE    = 4'd8;
    localparam logic [ACT_W-1:0] ACT_QUIET   = 4'd9;
    localparam logic [ACT_W-1:0] ACT_DELAY   = 4'd10;

    typedef struct packed {
        logic [TIME_W-1:0]  deadline;
        logic [IVAL_W-1:0]  period;
        logic [IVAL_W-1:0]  rep_total;
        logic [IVAL_W-1:0]  fire_count;
        logic [STAMP_W-1:0] stamp;
    } slot_rec_t;

    typedef struct packed {
        logic              status;
        logic [SLOT_W-1:0] id;
        logic              fired;
        logic              found;
    } result_t;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [SLOT_W-1:0] rd_addr;
        logic              rd_id_sel;
        logic              scan_clear;
        logic              scan_eval;
        logic [SLOT_W-1:0] buf_waddr;
        logic [SLOT_W-1:0] buf_raddr;
        logic              out_load;
        logic              out_last;
    } ctl_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            best_due;
        logic            fire_stop;
        logic            out_free;
    } sts_t;

endpackage

// ===== rtl/core/mts_if.sv =====
// Channel interfaces of the scheduler: command, result and configuration.
interface mts_cmd_if;
    import mts_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       operation;
    logic [IVAL_W-1:0]     interval_ms;
    logic [IVAL_W-1:0]     repeat_total;
    logic [SLOT_W-1:0]     timer_id;
    modport source (output valid, operation, interval_ms, repeat_total, timer_id,
                     input ready);
    modport sink   (input valid, operation, interval_ms, repeat_total, timer_id,
                     output ready);
endinterface

interface mts_rsp_if;
    import mts_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      status;
    logic [SLOT_W-1:0]         result_id;
    logic                      fired;
    logic                      found;
    logic signed [DELAY_W-1:0] next_delay;
    logic                      last;
    modport source (output valid, status, result_id, fired, found, next_delay, last,
                     input ready);
    modport sink   (input valid, status, result_id, fired, found, next_delay, last,
                     output ready);
endinterface

interface mts_cfg_if;
    import mts_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [IVAL_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/mts_ctrl.sv =====
// Sequencer of the scheduler: dispatch, slot scans, expiry loop and result drain.
module mts_ctrl
    import mts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  sts_t sts,
    output ctl_t ctl
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DISPATCH  = 3'd1;
    localparam logic [2:0] S_RESET     = 3'd2;
    localparam logic [2:0] S_SCAN      = 3'd3;
    localparam logic [2:0] S_SCAN_DONE = 3'd4;
    localparam logic [2:0] S_DRAIN_RD  = 3'd5;
    localparam logic [2:0] S_DRAIN_LD  = 3'd6;

    localparam logic [1:0] P_ADD   = 2'd0;
    localparam logic [1:0] P_TICK  = 2'd1;
    localparam logic [1:0] P_FINAL = 2'd2;

    logic [2:0]        state_reg, state_next;
    logic [SCAN_W-1:0] idx_reg, idx_next;
    logic [SCAN_W-1:0] n_reg, n_next;
    logic [SLOT_W-1:0] didx_reg, didx_next;
    logic [1:0]        purpose_reg, purpose_next;

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        didx_next    = didx_reg;
        purpose_next = purpose_reg;
        ctl          = '0;
        ctl.act      = ACT_NONE;
        ctl.rd_addr  = idx_reg[SLOT_W-1:0];
        ctl.buf_raddr = didx_reg;
        cmd_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctl.act    = ACT_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                idx_next     = '0;
                n_next       = SCAN_W'(1);
                purpose_next = P_FINAL;
                state_next   = S_SCAN;
                case (sts.op)
                    OP_ADD:    purpose_next = P_ADD;
                    OP_REMOVE: ctl.act = ACT_REMOVE;
                    OP_RESET:
                    begin
                        ctl.rd_id_sel = 1'b1;
                        state_next    = S_RESET;
                    end
                    OP_EXISTS: ctl.act = ACT_EXISTS;
                    OP_TICK:
                    begin
                        ctl.act      = ACT_ADVANCE;
                        n_next       = '0;
                        purpose_next = P_TICK;
                    end
                    default:   ctl.act = ACT_BAD;
                endcase
            end
            S_RESET:
            begin
                ctl.act    = ACT_RESET;
                idx_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                ctl.scan_clear = (idx_reg == '0);
                ctl.scan_eval  = (idx_reg != '0);
                if (idx_reg == SCAN_W'(TIMER_SLOTS))
                    state_next = S_SCAN_DONE;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_SCAN_DONE:
            begin
                idx_next = '0;
                case (purpose_reg)
                    P_ADD:
                    begin
                        ctl.act      = ACT_ADD;
                        purpose_next = P_FINAL;
                        state_next   = S_SCAN;
                    end
                    P_TICK:
                    begin
                        if (sts.best_due && (n_reg != SCAN_W'(TIMER_SLOTS)))
                        begin
                            ctl.act       = ACT_FIRE;
                            ctl.buf_waddr = n_reg[SLOT_W-1:0];
                            n_next        = n_reg + 1'b1;
                            state_next    = S_SCAN;
                            if (sts.fire_stop)
                                purpose_next = P_FINAL;
                        end
                        else if (n_reg == '0)
                        begin
                            ctl.act      = ACT_QUIET;
                            n_next       = SCAN_W'(1);
                            purpose_next = P_FINAL;
                            state_next   = S_SCAN;
                        end
                        else
                        begin
                            // last scan already reflects every fire
                            ctl.act    = ACT_DELAY;
                            didx_next  = '0;
                            state_next = S_DRAIN_RD;
                        end
                    end
                    default:
                    begin
                        ctl.act    = ACT_DELAY;
                        didx_next  = '0;
                        state_next = S_DRAIN_RD;
                    end
                endcase
            end
            S_DRAIN_RD:
            begin
                state_next = S_DRAIN_LD;
            end
            S_DRAIN_LD:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    ctl.out_last = (({1'b0, didx_reg} + 1'b1) == n_reg);
                    if (ctl.out_last)
                        state_next = S_IDLE;
                    else
                    begin
                        didx_next  = didx_reg + 1'b1;
                        state_next = S_DRAIN_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            n_reg       <= '0;
            didx_reg    <= '0;
            purpose_reg <= P_FINAL;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            n_reg       <= n_next;
            didx_reg    <= didx_next;
            purpose_reg <= purpose_next;
        end
    end

endmodule

// ===== rtl/core/mts_datapath.sv =====
// Datapath of the scheduler: slot memory, clock, scan tracker, result buffer, output register.
module mts_datapath
    import mts_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    mts_cmd_if.sink       cmd,
    mts_rsp_if.source     rsp,
    mts_cfg_if.sink       cfg,
    input  ctl_t          ctl,
    output sts_t          sts
);

    logic [IVAL_W-1:0]      min_reg, max_reg;
    logic [OP_W-1:0]        op_reg;
    logic [IVAL_W-1:0]      ival_reg, rep_reg;
    logic [SLOT_W-1:0]      id_reg;
    logic [TIME_W-1:0]      clock_reg, clock_next;
    logic [STAMP_W-1:0]     order_reg;
    logic [TIMER_SLOTS-1:0] active_reg, active_next;

    slot_rec_t              slot_mem [TIMER_SLOTS];
    slot_rec_t              rdata_reg;
    logic                   rd_act_reg;
    logic [SLOT_W-1:0]      rd_id_reg;
    logic [SLOT_W-1:0]      rd_addr;

    logic                   best_valid_reg, free_valid_reg;
    slot_rec_t              best_reg;
    logic [SLOT_W-1:0]      best_id_reg, free_id_reg;
    logic [DELAY_W-1:0]     delay_reg, delay_code;

    result_t                buf_mem [TIMER_SLOTS];
    result_t                buf_q_reg;

    logic                   out_valid_reg, out_last_reg;
    result_t                out_res_reg;
    logic [DELAY_W-1:0]     out_delay_reg;

    logic [IVAL_W-1:0]      ival_c, period_add, fire_cnt;
    logic [TIME_W:0]        add_sum, reset_sum, fire_sum;
    logic [TIME_W-1:0]      delay_diff;
    logic [STAMP_W-1:0]     stamp_diff;
    logic                   cand_before, fire_end, head_due;

    logic                   mem_we, buf_we, order_inc;
    logic [SLOT_W-1:0]      mem_waddr;
    slot_rec_t              mem_wdata;
    result_t                res;

    // clamp: raise to min first, otherwise lower to max, never zero
    always_comb
    begin
        if (ival_reg < min_reg)
            ival_c = min_reg;
        else if (ival_reg > max_reg)
            ival_c = max_reg;
        else
            ival_c = ival_reg;
        period_add = (ival_c == '0) ? IVAL_W'(1) : ival_c;
    end

    assign add_sum   = {1'b0, clock_reg} + (TIME_W + 1)'(period_add);
    assign reset_sum = {1'b0, clock_reg} + (TIME_W + 1)'(rdata_reg.period);
    assign fire_sum  = {1'b0, best_reg.deadline} + (TIME_W + 1)'(best_reg.period);
    assign fire_cnt  = (best_reg.fire_count == IVAL_MAX) ? IVAL_MAX
                                                         : best_reg.fire_count + 1'b1;
    assign fire_end  = (best_reg.rep_total != '0) && (fire_cnt >= best_reg.rep_total);
    assign head_due  = best_valid_reg && (best_reg.deadline <= clock_reg);

    assign stamp_diff  = rdata_reg.stamp - best_reg.stamp;
    assign cand_before = (rdata_reg.deadline < best_reg.deadline) ||
                         ((rdata_reg.deadline == best_reg.deadline) && stamp_diff[STAMP_W-1]);

    assign delay_diff = best_reg.deadline - clock_reg;
    always_comb
    begin
        if (!best_valid_reg)
            delay_code = DELAY_NONE;
        else if (best_reg.deadline <= clock_reg)
            delay_code = DELAY_W'(1);
        else if (|delay_diff[TIME_W-1:IVAL_W])
            delay_code = {1'b0, IVAL_MAX};
        else
            delay_code = {1'b0, delay_diff[IVAL_W-1:0]};
    end

    assign rd_addr = ctl.rd_id_sel ? id_reg : ctl.rd_addr;

    always_comb
    begin
        mem_we      = 1'b0;
        mem_waddr   = best_id_reg;
        mem_wdata   = best_reg;
        active_next = active_reg;
        clock_next  = clock_reg;
        order_inc   = 1'b0;
        buf_we      = 1'b0;
        res         = '0;
        case (ctl.act)
            ACT_ADD:
            begin
                buf_we = 1'b1;
                if (!free_valid_reg || add_sum[TIME_W])
                    res.status = 1'b1;
                else
                begin
                    mem_we               = 1'b1;
                    mem_waddr            = free_id_reg;
                    mem_wdata.deadline   = add_sum[TIME_W-1:0];
                    mem_wdata.period     = period_add;
                    mem_wdata.rep_total  = rep_reg;
                    mem_wdata.fire_count = '0;
                    mem_wdata.stamp      = order_reg;
                    order_inc            = 1'b1;
                    active_next[free_id_reg] = 1'b1;
                    res.id               = free_id_reg;
                end
            end
            ACT_REMOVE:
            begin
                buf_we = 1'b1;
                res.id = id_reg;
                if (active_reg[id_reg])
                    active_next[id_reg] = 1'b0;
                else
                    res.status = 1'b1;
            end
            ACT_RESET:
            begin
                buf_we = 1'b1;
                res.id = id_reg;
                if (!active_reg[id_reg])
                    res.status = 1'b1;
                else if (reset_sum[TIME_W])
                begin
                    active_next[id_reg] = 1'b0;
                    res.status          = 1'b1;
                end
                else
                begin
                    mem_we               = 1'b1;
                    mem_waddr            = id_reg;
                    mem_wdata            = rdata_reg;
                    mem_wdata.deadline   = reset_sum[TIME_W-1:0];
                    mem_wdata.fire_count = '0;
                    mem_wdata.stamp      = order_reg;
                    order_inc            = 1'b1;
                end
            end
            ACT_EXISTS:
            begin
                buf_we    = 1'b1;
                res.id    = id_reg;
                res.found = active_reg[id_reg];
            end
            ACT_BAD:
            begin
                buf_we     = 1'b1;
                res.status = 1'b1;
            end
            ACT_ADVANCE:
            begin
                if (clock_reg != TIME_MAX)
                    clock_next = clock_reg + 1'b1;
            end
            ACT_FIRE:
            begin
                buf_we = 1'b1;
                res.id = best_id_reg;
                if (fire_end)
                begin
                    active_next[best_id_reg] = 1'b0;
                    res.fired                = 1'b1;
                end
                else if (fire_sum[TIME_W])
                begin
                    active_next[best_id_reg] = 1'b0;
                    res.status               = 1'b1;
                end
                else
                begin
                    mem_we               = 1'b1;
                    mem_wdata.deadline   = fire_sum[TIME_W-1:0];
                    mem_wdata.fire_count = fire_cnt;
                    mem_wdata.stamp      = order_reg;
                    order_inc            = 1'b1;
                    res.fired            = 1'b1;
                end
            end
            ACT_QUIET:
            begin
                buf_we = 1'b1;
            end
            default:
            begin
                buf_we = 1'b0;
            end
        endcase
    end

    assign sts.op        = op_reg;
    assign sts.best_due  = head_due;
    assign sts.fire_stop = !fire_end && fire_sum[TIME_W];
    assign sts.out_free  = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg        <= MIN_INTERVAL_RESET;
            max_reg        <= MAX_INTERVAL_RESET;
            clock_reg      <= '0;
            order_reg      <= '0;
            active_reg     <= '0;
            best_valid_reg <= 1'b0;
            free_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_MIN_INTERVAL: min_reg <= cfg.data;
                    CFG_MAX_INTERVAL: max_reg <= cfg.data;
                    default:          min_reg <= min_reg;
                endcase
            end
            clock_reg  <= clock_next;
            active_reg <= active_next;
            if (order_inc)
                order_reg <= order_reg + 1'b1;
            if (ctl.scan_clear)
            begin
                best_valid_reg <= 1'b0;
                free_valid_reg <= 1'b0;
            end
            else if (ctl.scan_eval)
            begin
                if (rd_act_reg && (!best_valid_reg || cand_before))
                    best_valid_reg <= 1'b1;
                if (!rd_act_reg)
                    free_valid_reg <= 1'b1;
            end
            if (ctl.out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers: scan tracker, captured item, delay, output
    always_ff @(posedge clk)
    begin
        if (ctl.act == ACT_CAPTURE)
        begin
            op_reg   <= cmd.operation;
            ival_reg <= cmd.interval_ms;
            rep_reg  <= cmd.repeat_total;
            id_reg   <= cmd.timer_id;
        end
        if (ctl.scan_eval)
        begin
            if (rd_act_reg && (!best_valid_reg || cand_before))
            begin
                best_reg    <= rdata_reg;
                best_id_reg <= rd_id_reg;
            end
            if (!rd_act_reg && !free_valid_reg)
                free_id_reg <= rd_id_reg;
        end
        if (ctl.act == ACT_DELAY)
            delay_reg <= delay_code;
        if (ctl.out_load)
        begin
            out_res_reg   <= buf_q_reg;
            out_delay_reg <= delay_reg;
            out_last_reg  <= ctl.out_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[mem_waddr] <= mem_wdata;
        rdata_reg  <= slot_mem[rd_addr];
        rd_act_reg <= active_reg[rd_addr];
        rd_id_reg  <= rd_addr;
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
            buf_mem[ctl.buf_waddr] <= res;
        buf_q_reg <= buf_mem[ctl.buf_raddr];
    end

    assign cfg.ready      = 1'b1;
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_res_reg.status;
    assign rsp.result_id  = out_res_reg.id;
    assign rsp.fired      = out_res_reg.fired;
    assign rsp.found      = out_res_reg.found;
    assign rsp.next_delay = out_delay_reg;
    assign rsp.last       = out_last_reg;

endmodule

// ===== rtl/core/multi_timer_deadline_scheduler.sv =====
// Top level of the multi-timer deadline scheduler.
// The block keeps 64 timer slots and a saturating millisecond clock. Each command
// item (add, remove, reset, exists, tick) is taken only while the block is idle and
// yields one or more result items, the final one marked by last; every result of an
// item carries the delay to the earliest armed deadline as it stands once the item
// is fully handled. Work proceeds in sweeps over the slot memory, which has a
// single registered read port; a sweep reads every slot in turn and ends in a
// scan-done step. Every item first passes through capture and dispatch. Remove,
// exists and unknown codes then take one sweep, reset one sweep after a step that
// reads its slot, add two sweeps; a tick that reports k >= 1 expiries takes k + 1
// sweeps (a deadline overflow ends the loop and counts among the k), and a quiet
// tick takes two sweeps. Results then drain from the buffer, stalling on the sink.
// A finished result sits in an output register, so the next command is taken while
// it waits. Configuration writes are taken in any cycle.
module multi_timer_deadline_scheduler
    import mts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    mts_cmd_if.sink   cmd,
    mts_rsp_if.source rsp,
    mts_cfg_if.sink   cfg
);

    ctl_t ctl;
    sts_t sts;
    logic cmd_ready;

    // sequencer: owns the flow of every item
    mts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    // datapath: slot storage, clock, head search, result buffer
    mts_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp),
        .cfg   (cfg),
        .ctl   (ctl),
        .sts   (sts)
    );

    assign cmd.ready = cmd_ready;

    // a taken item makes the block busy at once
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("command taken while previous item still in work");

    // only a due queue head may be fired
    a_fire_due: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.act == ACT_FIRE) |-> sts.best_due)
        else $error("fire issued for a head that is not due");

    // never overwrite a result the sink has not taken
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!rsp.valid || rsp.ready))
        else $error("output register overwritten while stalled");

endmodule
